// ===== src/integer_to_roman_encoder_defines.svh =====
`ifndef INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH
`define INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, held off during reset
`define I2R_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, held off during reset
`define I2R_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/i2r_pkg.sv =====
`timescale 1ns / 1ps

package i2r_pkg;

	localparam int NUM_W   = 12;
	localparam int LET_W   = 7;
	localparam int ENTRIES = 13;
	localparam int IDX_W   = 4;

	localparam logic [NUM_W-1:0] LIMIT = 12'd3999;

	// ascii letters
	localparam logic [LET_W-1:0] CH_NONE = 7'h00;
	localparam logic [LET_W-1:0] CH_I    = 7'h49;
	localparam logic [LET_W-1:0] CH_V    = 7'h56;
	localparam logic [LET_W-1:0] CH_X    = 7'h58;
	localparam logic [LET_W-1:0] CH_L    = 7'h4C;
	localparam logic [LET_W-1:0] CH_C    = 7'h43;
	localparam logic [LET_W-1:0] CH_D    = 7'h44;
	localparam logic [LET_W-1:0] CH_M    = 7'h4D;

	// greedy table, highest value first
	localparam logic [NUM_W-1:0] VALUE [ENTRIES] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};

	localparam logic [LET_W-1:0] LEAD_GLYPH [ENTRIES] = '{
		CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
	};

	// second letter of a subtractive pair, none for single letters
	localparam logic [LET_W-1:0] TRAIL_GLYPH [ENTRIES] = '{
		CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
		CH_X, CH_NONE, CH_V, CH_NONE
	};

	localparam logic [ENTRIES-1:0] IS_PAIR = 13'b0_1010_1010_1010;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_LEAD  = 3'b010,
		ST_TRAIL = 3'b100
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic load_err;
		logic emit;
		logic second;
		logic subtract;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;
		logic pair;
		logic done;
	} status_t;

	// largest table entry not above n
	function automatic logic [IDX_W-1:0] pick_entry(input logic [NUM_W-1:0] n);
		logic [IDX_W-1:0] idx;
		idx = IDX_W'(ENTRIES - 1);
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if (n >= VALUE[k]) begin
				idx = IDX_W'(k);
			end
		end
		return idx;
	endfunction

endpackage

// ===== src/i2r_datapath.sv =====
`timescale 1ns / 1ps

module i2r_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [i2r_pkg::NUM_W-1:0]     number,
	input  i2r_pkg::cmd_t                 cmd,
	output i2r_pkg::status_t              sts,
	output logic                          strobe,
	output logic [i2r_pkg::LET_W-1:0]     letter,
	output logic                          last,
	output logic                          error
);

	logic [i2r_pkg::NUM_W-1:0] rem_q;
	logic [i2r_pkg::IDX_W-1:0] idx;
	logic                      strobe_q;
	logic [i2r_pkg::LET_W-1:0] letter_q;
	logic                      last_q;
	logic                      error_q;

	// table lookup on the remaining value
	always_comb begin
		idx      = i2r_pkg::pick_entry(rem_q);
		sts.bad  = (number == '0) || (number > i2r_pkg::LIMIT);
		sts.pair = i2r_pkg::IS_PAIR[idx];
		sts.done = (rem_q == i2r_pkg::VALUE[idx]);
	end

	// remaining value
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= number;
		end else if (cmd.subtract) begin
			rem_q <= rem_q - i2r_pkg::VALUE[idx];
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit || cmd.load_err;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			letter_q <= i2r_pkg::CH_NONE;
			last_q   <= 1'b1;
			error_q  <= 1'b1;
		end else if (cmd.emit) begin
			letter_q <= cmd.second ? i2r_pkg::TRAIL_GLYPH[idx] : i2r_pkg::LEAD_GLYPH[idx];
			last_q   <= cmd.subtract && sts.done;
			error_q  <= 1'b0;
		end
	end

	assign strobe = strobe_q;
	assign letter = letter_q;
	assign last   = last_q;
	assign error  = error_q;

endmodule

// ===== src/i2r_ctrl.sv =====
`timescale 1ns / 1ps

module i2r_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  i2r_pkg::status_t sts,
	output i2r_pkg::cmd_t    cmd,
	output logic             busy
);

	i2r_pkg::state_t state_q;
	i2r_pkg::state_t state_d;

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			i2r_pkg::ST_IDLE: begin
				if (start) begin
					if (sts.bad) begin
						cmd.load_err = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = i2r_pkg::ST_LEAD;
					end
				end
			end
			i2r_pkg::ST_LEAD: begin
				cmd.emit = 1'b1;
				if (sts.pair) begin
					state_d = i2r_pkg::ST_TRAIL;
				end else begin
					cmd.subtract = 1'b1;
					state_d      = sts.done ? i2r_pkg::ST_IDLE : i2r_pkg::ST_LEAD;
				end
			end
			i2r_pkg::ST_TRAIL: begin
				cmd.emit     = 1'b1;
				cmd.second   = 1'b1;
				cmd.subtract = 1'b1;
				state_d      = sts.done ? i2r_pkg::ST_IDLE : i2r_pkg::ST_LEAD;
			end
			default: begin
				state_d = i2r_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2r_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != i2r_pkg::ST_IDLE);

endmodule

// ===== src/integer_to_roman_encoder.sv =====
// the first letter is registered once the number is loaded and the state is lead, then
// one letter per cycle; busy is high while a valid number's letters (1 to 15) are emitted,
// one table lookup each, and the next number is taken once busy drops; an invalid number
// gives its error result in the cycle after start and never raises busy
// results go out on a one-cycle strobe; the receiver cannot stall
// arst_n clears the controller to idle and drops the strobe; payload is not reset
`timescale 1ns / 1ps

`include "integer_to_roman_encoder_defines.svh"

module integer_to_roman_encoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [i2r_pkg::NUM_W-1:0] number,
	output logic                      strobe,
	output logic [i2r_pkg::LET_W-1:0] letter,
	output logic                      last,
	output logic                      error
);

	i2r_pkg::cmd_t    cmd;
	i2r_pkg::status_t sts;

	// sequencer
	i2r_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// value register, table and result register
	i2r_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number),
		.cmd    (cmd),
		.sts    (sts),
		.strobe (strobe),
		.letter (letter),
		.last   (last),
		.error  (error)
	);

	// checks
	`I2R_ASSERT_NOW(a_err_is_single, strobe && error, last && (letter == '0), "error result must be last with no letter")
	`I2R_ASSERT_NOW(a_run_continues, strobe && !last && !error, busy, "controller left a run before its last letter")
	`I2R_ASSERT_NEXT(a_bad_number, start && !busy && ((number == '0) || (number > i2r_pkg::LIMIT)), strobe && error && !busy, "invalid number did not give an error result")
	`I2R_ASSERT_NEXT(a_good_number, start && !busy && (number != '0) && (number <= i2r_pkg::LIMIT), busy && !strobe, "valid number did not start a run")

endmodule

// ===== test/integer_to_roman_encoder_tb.sv =====
`timescale 1ns / 1ps

module integer_to_roman_encoder_tb;

	localparam int          NUM_W       = i2r_pkg::NUM_W;
	localparam int          LET_W       = i2r_pkg::LET_W;
	localparam int unsigned ROMAN_MAX   = 3999;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          DRAIN_WAIT  = 8;

	// one letter of a numeral as it leaves the block
	typedef struct packed {
		logic [LET_W-1:0] letter;
		logic             last;
		logic             error;
	} numeral_letter_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [NUM_W-1:0] number;
	logic             strobe;
	logic [LET_W-1:0] letter;
	logic             last;
	logic             error;

	// greedy symbol table, largest value first
	int unsigned roman_value [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
	string       roman_symbol [13] = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX",
		"V", "IV", "I"};

	numeral_letter_t pending_letters [$];
	int              idle_pct;
	int              mismatch_count;
	int              numbers_sent;
	int              invalid_sent;
	int              letters_checked;
	int              cycle_count;

	integer_to_roman_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.number (number),
		.strobe (strobe),
		.letter (letter),
		.last   (last),
		.error  (error)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// queue the letters that one number should produce
	function automatic void predict_numeral(input logic [NUM_W-1:0] n);
		int unsigned     remain;
		numeral_letter_t item;
		byte             ch;
		remain = n;
		if (remain == 0 || remain > ROMAN_MAX) begin
			item.letter = '0;
			item.last   = 1'b1;
			item.error  = 1'b1;
			pending_letters.push_back(item);
			invalid_sent++;
			return;
		end
		for (int i = 0; i < 13; i++) begin
			while (remain >= roman_value[i]) begin
				for (int j = 0; j < roman_symbol[i].len(); j++) begin
					ch          = roman_symbol[i][j];
					item.letter = ch[LET_W-1:0];
					item.last   = 1'b0;
					item.error  = 1'b0;
					pending_letters.push_back(item);
				end
				remain -= roman_value[i];
			end
		end
		// mark the final letter of the run
		item      = pending_letters.pop_back();
		item.last = 1'b1;
		pending_letters.push_back(item);
	endfunction

	// random number, weighted toward valid values with some long runs
	function automatic logic [NUM_W-1:0] random_number();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 4) begin
			return '0;
		end else if (pick < 10) begin
			return NUM_W'($urandom_range(4095, ROMAN_MAX + 1));
		end else if (pick < 25) begin
			return NUM_W'($urandom_range(60, 1));
		end else if (pick < 40) begin
			return NUM_W'($urandom_range(ROMAN_MAX, 3000));
		end
		return NUM_W'($urandom_range(ROMAN_MAX, 1));
	endfunction

	// one transfer of a number, with an optional idle gap ahead of it
	task automatic send_number(input logic [NUM_W-1:0] n);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start  <= 1'b1;
		number <= n;
		do @(posedge clk); while (busy);
		predict_numeral(n);
		numbers_sent++;
	endtask

	task automatic test_directed_values();
		logic [NUM_W-1:0] corner [21] = '{
			12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90, 12'd100,
			12'd400, 12'd500, 12'd900, 12'd1000, 12'd3888, 12'd3999, 12'd4000, 12'd4095,
			12'd1994, 12'd2048, 12'd3
		};
		idle_pct = 0;
		foreach (corner[i]) begin
			send_number(corner[i]);
		end
	endtask

	task automatic test_back_to_back();
		idle_pct = 0;
		repeat (50) send_number(random_number());
	endtask

	task automatic test_sparse_sender();
		idle_pct = 88;
		repeat (45) send_number(random_number());
	endtask

	task automatic test_mixed_idle();
		idle_pct = 27;
		repeat (50) send_number(random_number());
	endtask

	// compare every letter transfer with the oldest prediction
	always @(posedge clk) begin : check_letters
		numeral_letter_t want;
		if (arst_n && strobe) begin
			if (pending_letters.size() == 0) begin
				$display("%0t: unexpected letter: expected none, got letter %h last %b error %b",
					$time, letter, last, error);
				mismatch_count++;
			end else begin
				want = pending_letters.pop_front();
				letters_checked++;
				if (letter !== want.letter) begin
					$display("%0t: letter mismatch: expected %h, got %h",
						$time, want.letter, letter);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last mismatch: expected %b, got %b", $time, want.last, last);
					mismatch_count++;
				end
				if (error !== want.error) begin
					$display("%0t: error mismatch: expected %b, got %b",
						$time, want.error, error);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d letters still expected", $time,
				pending_letters.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		number          = '0;
		idle_pct        = 0;
		mismatch_count  = 0;
		numbers_sent    = 0;
		invalid_sent    = 0;
		letters_checked = 0;
		cycle_count     = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_values();
		test_back_to_back();
		test_sparse_sender();
		test_mixed_idle();
		start <= 1'b0;

		// drain the remaining letters, then let the block settle
		while (pending_letters.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("converted %0d numbers (%0d out of range) across back-to-back and idle phases",
			numbers_sent, invalid_sent);
		$display("checked %0d letters, %0d mismatches", letters_checked, mismatch_count);
		if (mismatch_count == 0 && pending_letters.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
